// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

   localparam int LINES_DEF       = 4;
   localparam int DEPTH_DEF       = 4096;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int GAIN_W     = 16;
   localparam int FRAC_W     = 14;
   localparam int ONE_Q14    = 16384;
   localparam int LINE_IDX_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEN_LEFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEN_RIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CROSS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SELF      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_WET   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MATRIX    = 3'd7;

   // matrix kinds
   localparam logic [1:0] MAT_ZERO  = 2'd0;
   localparam logic [1:0] MAT_HOUSE = 2'd1;
   localparam logic [1:0] MAT_HADA  = 2'd2;

   // accumulator operations
   localparam logic [1:0] MAC_NONE = 2'd0;
   localparam logic [1:0] MAC_CLR  = 2'd1;
   localparam logic [1:0] MAC_ADD  = 2'd2;
   localparam logic [1:0] MAC_SUB  = 2'd3;

   // multiplier operand pairs
   localparam logic [2:0] SEL_MIX   = 3'd0;
   localparam logic [2:0] SEL_SELF  = 3'd1;
   localparam logic [2:0] SEL_TOT   = 3'd2;
   localparam logic [2:0] SEL_OWN   = 3'd3;
   localparam logic [2:0] SEL_OTHER = 3'd4;
   localparam logic [2:0] SEL_WET   = 3'd5;
   localparam logic [2:0] SEL_DRY   = 3'd6;

   typedef struct packed {
      logic [2:0]            sel;
      logic [1:0]            op;
      logic [LINE_IDX_W-1:0] line;
      logic                  fb_load;
      logic                  wr;
      logic                  rd;
      logic                  clr;
   } sfr_ctl_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] cross_gain;
      logic [4*GAIN_W-1:0]      self_gains;
      logic signed [GAIN_W-1:0] total_gain;
      logic signed [GAIN_W-1:0] spread;
      logic signed [GAIN_W-1:0] wet_gain;
      logic signed [GAIN_W-1:0] dry_gain;
      logic [1:0]               matrix_kind;
   } sfr_cfg_type;

   function automatic logic signed [1:0] mat_sign(input logic [1:0] kind,
                                                  input logic [LINE_IDX_W-1:0] i,
                                                  input logic [LINE_IDX_W-1:0] n);
      logic [LINE_IDX_W-1:0] a;
      a = i & n;
      case (kind)
         MAT_HOUSE: return (i == n) ? 2'sd1 : -2'sd1;
         MAT_HADA:  return (a[0] ^ a[1]) ? -2'sd1 : 2'sd1;
         default:   return 2'sd0;
      endcase
   endfunction

endpackage

// ===== hdl/sfr_ram.sv =====
module sfr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/sfr_mac.sv =====
module sfr_mac #(
   parameter int A_W   = 32,
   parameter int B_W   = 16,
   parameter int ACC_W = 50
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              op,
   input  logic signed [A_W-1:0]   a,
   input  logic signed [B_W-1:0]   b,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [A_W+B_W-1:0] prod_ff;
   logic [1:0]                op_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in, prod_ext;

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (op_ff)
         sfr_pkg::MAC_CLR: acc_in = prod_ext;
         sfr_pkg::MAC_ADD: acc_in = acc_ff + prod_ext;
         sfr_pkg::MAC_SUB: acc_in = acc_ff - prod_ext;
         default:          acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= sfr_pkg::MAC_NONE;
      end else begin
         op_ff <= op;
      end
      prod_ff <= a * b;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== hdl/sfr_chan.sv =====
module sfr_chan #(
   parameter int LINES       = sfr_pkg::LINES_DEF,
   parameter int DEPTH       = sfr_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = sfr_pkg::SAMPLE_BITS_DEF,
   localparam int PTR_W  = $clog2(DEPTH),
   localparam int ADDR_W = $clog2(LINES * DEPTH),
   localparam int FB_W   = SAMPLE_BITS + 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sfr_pkg::sfr_ctl_type          ctl,
   input  sfr_pkg::sfr_cfg_type          cfg,
   input  logic [4*sfr_pkg::GAIN_W-1:0]  lengths,
   input  logic signed [SAMPLE_BITS-1:0] in_smp,
   input  logic [PTR_W-1:0]              ptr,
   input  logic [ADDR_W-1:0]             clr_addr,
   input  logic signed [FB_W-1:0]        fb_other,
   output logic signed [FB_W-1:0]        fb,
   output logic signed [SAMPLE_BITS-1:0] out_smp
);

   localparam int S      = SAMPLE_BITS;
   localparam int LINE_W = (LINES > 2) ? 2 : 1;
   localparam int TOT_W  = S + 2;
   localparam int A_W    = FB_W;
   localparam int B_W    = sfr_pkg::GAIN_W;
   localparam int ACC_W  = S + 26;
   localparam int PW1    = PTR_W + 1;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (sfr_pkg::FRAC_W - 1));
   localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (S - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

   function automatic logic signed [S-1:0] sat(input logic signed [ACC_W-1:0] v);
      if (v > SMAX) return SMAX[S-1:0];
      if (v < SMIN) return SMIN[S-1:0];
      return v[S-1:0];
   endfunction

   logic signed [S-1:0]     taps_ff [LINES];
   logic signed [TOT_W-1:0] tot, macc, mix;
   logic [LINE_W-1:0]       lidx;
   logic signed [B_W-1:0]   sg, one_minus;
   logic signed [A_W-1:0]   op_a;
   logic signed [B_W-1:0]   op_b;
   logic signed [ACC_W-1:0] acc, rnd, wsum;
   logic signed [FB_W-1:0]  fb_ff;
   logic [15:0]             len16;
   logic [PTR_W-1:0]        lenc, wpos;
   logic [PW1-1:0]          psum;
   logic [ADDR_W-1:0]       base, waddr, raddr, ram_waddr;
   logic [S-1:0]            rdata, ram_wdata;
   logic                    rd_pend_ff;
   logic [LINE_W-1:0]       rd_line_ff;

   assign lidx = ctl.line[LINE_W-1:0];

   always_comb begin
      tot  = '0;
      macc = '0;
      for (int n = 0; n < LINES; n++) begin
         tot = tot + TOT_W'(taps_ff[n]);
         case (sfr_pkg::mat_sign(cfg.matrix_kind, ctl.line, sfr_pkg::LINE_IDX_W'(n)))
            2'sd1:   macc = macc + TOT_W'(taps_ff[n]);
            -2'sd1:  macc = macc - TOT_W'(taps_ff[n]);
            default: macc = macc;
         endcase
      end
      mix = (macc + TOT_W'(1)) >>> 1;
   end

   assign sg        = signed'(cfg.self_gains[16*lidx +: 16]);
   assign one_minus = B_W'(sfr_pkg::ONE_Q14) - cfg.spread;

   always_comb begin
      case (ctl.sel)
         sfr_pkg::SEL_MIX:   begin op_a = A_W'(mix);          op_b = cfg.cross_gain; end
         sfr_pkg::SEL_SELF:  begin op_a = A_W'(taps_ff[lidx]); op_b = sg;            end
         sfr_pkg::SEL_TOT:   begin op_a = A_W'(tot);          op_b = cfg.total_gain; end
         sfr_pkg::SEL_OWN:   begin op_a = fb_ff;              op_b = one_minus;      end
         sfr_pkg::SEL_OTHER: begin op_a = fb_other;           op_b = cfg.spread;     end
         sfr_pkg::SEL_WET:   begin op_a = A_W'(tot);          op_b = cfg.wet_gain;   end
         sfr_pkg::SEL_DRY:   begin op_a = A_W'(in_smp);       op_b = cfg.dry_gain;   end
         default:            begin op_a = '0;                 op_b = '0;             end
      endcase
   end

   sfr_mac #(.A_W(A_W), .B_W(B_W), .ACC_W(ACC_W)) u_mac (
      .clock (clock),
      .reset (reset),
      .op    (ctl.op),
      .a     (op_a),
      .b     (op_b),
      .acc   (acc)
   );

   assign rnd     = (acc + HALF) >>> sfr_pkg::FRAC_W;
   assign wsum    = ACC_W'(in_smp) + rnd;
   assign out_smp = sat(rnd);

   // write position: pointer plus clamped length, wrapped
   always_comb begin
      len16 = lengths[16*lidx +: 16];
      lenc  = ({1'b0, len16} >= 17'(DEPTH)) ? PTR_W'(DEPTH - 1) : PTR_W'(len16);
      psum  = {1'b0, ptr} + {1'b0, lenc};
      wpos  = (psum >= PW1'(DEPTH)) ? PTR_W'(psum - PW1'(DEPTH)) : psum[PTR_W-1:0];
      base  = ADDR_W'(ADDR_W'(lidx) * ADDR_W'(DEPTH));
      waddr = base + ADDR_W'(wpos);
      raddr = base + ADDR_W'(ptr);
   end

   assign ram_waddr = ctl.clr ? clr_addr : waddr;
   assign ram_wdata = ctl.clr ? '0 : sat(wsum);

   sfr_ram #(.WIDTH(S), .DEPTH(LINES * DEPTH)) u_ram (
      .clock (clock),
      .we    (ctl.wr | ctl.clr),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         for (int n = 0; n < LINES; n++) begin
            taps_ff[n] <= '0;
         end
      end else begin
         rd_pend_ff <= ctl.rd;
         if (rd_pend_ff) begin
            taps_ff[rd_line_ff] <= signed'(rdata);
         end
      end
      rd_line_ff <= lidx;
      if (ctl.fb_load) begin
         fb_ff <= FB_W'(rnd);
      end
   end

   assign fb = fb_ff;

endmodule

// ===== hdl/stereo_fdn_reverb.sv =====
// Stereo four-line feedback delay network reverb. One stereo sample goes in
// on req_ and one comes out on rsp_; each item is worked through by the
// single multiply-accumulate unit per channel, which forms three feedback
// products and two blend products for each line, then one tap read per line
// from the channel's delay memory and the wet/dry products. The next sample
// may be accepted while a result still waits on rsp_. After reset the delay
// memories are cleared, one entry per cycle; req_tready stays low meanwhile
// while csr_ writes are taken at any time. Write configuration only while
// idle.
module stereo_fdn_reverb #(
   parameter int LINES       = sfr_pkg::LINES_DEF,
   parameter int DELAY_DEPTH = sfr_pkg::DEPTH_DEF,
   parameter int SAMPLE_BITS = sfr_pkg::SAMPLE_BITS_DEF,
   localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [DATA_W-1:0]                req_tdata,  // in_left, in_right
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [DATA_W-1:0]                rsp_tdata,  // out_left, out_right
   input  logic                             csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int S      = SAMPLE_BITS;
   localparam int PTR_W  = $clog2(DELAY_DEPTH);
   localparam int ADDR_W = $clog2(LINES * DELAY_DEPTH);
   localparam int FB_W   = S + 8;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FB    = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_WET   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [3:0] FB_LAST = 4'd8;

   logic [63:0]     len_l_ff, len_r_ff, self_ff;
   logic [15:0]     cross_ff, total_ff;
   logic [14:0]     spread_ff;
   logic [31:0]     dry_wet_ff;
   logic [1:0]      kind_ff;

   logic [2:0]      state_ff, state_in;
   logic [3:0]      step_ff, step_in;
   logic [sfr_pkg::LINE_IDX_W-1:0] line_ff, line_in;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [PTR_W-1:0]  ptr_ff;
   logic signed [S-1:0] in_l_ff, in_r_ff, out_l, out_r, rsp_l_ff, rsp_r_ff;
   logic            rsp_valid_ff, out_load, accept;
   logic signed [FB_W-1:0] fb_l, fb_r;

   sfr_pkg::sfr_ctl_type ctl;
   sfr_pkg::sfr_cfg_type cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_l_ff   <= '0;
         len_r_ff   <= '0;
         cross_ff   <= '0;
         self_ff    <= '0;
         total_ff   <= '0;
         spread_ff  <= '0;
         dry_wet_ff <= '0;
         kind_ff    <= sfr_pkg::MAT_ZERO;
      end else if (csr_we) begin
         case (csr_index)
            sfr_pkg::REG_LEN_LEFT:  len_l_ff   <= csr_wdata;
            sfr_pkg::REG_LEN_RIGHT: len_r_ff   <= csr_wdata;
            sfr_pkg::REG_CROSS:     cross_ff   <= csr_wdata[15:0];
            sfr_pkg::REG_SELF:      self_ff    <= csr_wdata;
            sfr_pkg::REG_TOTAL:     total_ff   <= csr_wdata[15:0];
            sfr_pkg::REG_SPREAD:    spread_ff  <= csr_wdata[14:0];
            sfr_pkg::REG_DRY_WET:   dry_wet_ff <= csr_wdata[31:0];
            sfr_pkg::REG_MATRIX:    kind_ff    <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.cross_gain  = signed'(cross_ff);
      cfg.self_gains  = self_ff;
      cfg.total_gain  = signed'(total_ff);
      // spread saturates at one
      cfg.spread      = (spread_ff > 15'd16384) ? 16'sd16384 : signed'({1'b0, spread_ff});
      cfg.wet_gain    = signed'(dry_wet_ff[31:16]);
      cfg.dry_gain    = signed'(dry_wet_ff[15:0]);
      cfg.matrix_kind = kind_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctl = '0;
      ctl.sel = sfr_pkg::SEL_MIX;
      ctl.op  = sfr_pkg::MAC_NONE;
      state_in = state_ff;
      step_in  = step_ff + 4'd1;
      line_in  = line_ff;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clr = 1'b1;
            step_in = '0;
            if (clr_cnt_ff == ADDR_W'(LINES * DELAY_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            step_in = '0;
            line_in = '0;
            if (accept) state_in = ST_FB;
         end
         ST_FB: begin
            ctl.line = line_ff;
            case (step_ff)
               4'd0: begin ctl.sel = sfr_pkg::SEL_MIX;   ctl.op = sfr_pkg::MAC_CLR; end
               4'd1: begin ctl.sel = sfr_pkg::SEL_SELF;  ctl.op = sfr_pkg::MAC_ADD; end
               4'd2: begin ctl.sel = sfr_pkg::SEL_TOT;   ctl.op = sfr_pkg::MAC_SUB; end
               4'd4: ctl.fb_load = 1'b1;
               4'd5: begin ctl.sel = sfr_pkg::SEL_OWN;   ctl.op = sfr_pkg::MAC_CLR; end
               4'd6: begin ctl.sel = sfr_pkg::SEL_OTHER; ctl.op = sfr_pkg::MAC_ADD; end
               4'd8: ctl.wr = 1'b1;
               default: ;
            endcase
            if (step_ff == FB_LAST) begin
               step_in = '0;
               if (line_ff == sfr_pkg::LINE_IDX_W'(LINES - 1)) begin
                  state_in = ST_RD;
               end else begin
                  line_in = line_ff + 1'b1;
               end
            end
         end
         ST_RD: begin
            // issue one read per line, last one lands in the final step
            if (step_ff < 4'(LINES)) begin
               ctl.rd   = 1'b1;
               ctl.line = step_ff[sfr_pkg::LINE_IDX_W-1:0];
            end else begin
               step_in  = '0;
               state_in = ST_WET;
            end
         end
         ST_WET: begin
            case (step_ff)
               4'd0: begin ctl.sel = sfr_pkg::SEL_WET; ctl.op = sfr_pkg::MAC_CLR; end
               4'd1: begin ctl.sel = sfr_pkg::SEL_DRY; ctl.op = sfr_pkg::MAC_ADD; end
               default: ;
            endcase
            if (step_ff == 4'd3) state_in = ST_DONE;
         end
         ST_DONE: begin
            step_in = '0;
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         line_ff      <= '0;
         clr_cnt_ff   <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         line_ff  <= line_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         // advance the pointer once all taps are read
         if (state_ff == ST_RD && state_in == ST_WET) begin
            ptr_ff <= (ptr_ff == PTR_W'(DELAY_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         in_l_ff <= signed'(req_tdata[S-1:0]);
         in_r_ff <= signed'(req_tdata[2*S-1:S]);
      end
      if (out_load) begin
         rsp_l_ff <= out_l;
         rsp_r_ff <= out_r;
      end
   end

   sfr_chan #(.LINES(LINES), .DEPTH(DELAY_DEPTH), .SAMPLE_BITS(S)) u_left (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .cfg      (cfg),
      .lengths  (len_l_ff),
      .in_smp   (in_l_ff),
      .ptr      (ptr_ff),
      .clr_addr (clr_cnt_ff),
      .fb_other (fb_r),
      .fb       (fb_l),
      .out_smp  (out_l)
   );

   sfr_chan #(.LINES(LINES), .DEPTH(DELAY_DEPTH), .SAMPLE_BITS(S)) u_right (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .cfg      (cfg),
      .lengths  (len_r_ff),
      .in_smp   (in_r_ff),
      .ptr      (ptr_ff),
      .clr_addr (clr_cnt_ff),
      .fb_other (fb_l),
      .fb       (fb_r),
      .out_smp  (out_r)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'({rsp_r_ff, rsp_l_ff});

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_FB)
      else $error("accepted sample did not start feedback phase");

   a_rsp_from_done : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   a_line_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FB |-> 32'(line_ff) < LINES)
      else $error("line index out of range");

   a_ptr_hold : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FB || state_ff == ST_IDLE) |=> $stable(ptr_ff) || $past(reset))
      else $error("pointer moved outside read phase");

endmodule
